// ===== hdl/cll_pkg.sv =====
// Shared types, constants and microcode ROM for the cursor linked list.
`timescale 1ns / 1ps

package cll_pkg;

   localparam int CLL_CAPACITY   = 64;
   localparam int CLL_DATA_WIDTH = 32;

   localparam int OP_W   = 4;
   localparam int WORD_W = 32;
   localparam int REQ_W  = ((OP_W + WORD_W + 7) / 8) * 8;
   localparam int STAT_W = 2;
   localparam int UPC_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_START      = 4'd0,
      OP_END        = 4'd1,
      OP_FORWARD    = 4'd2,
      OP_BACKWARD   = 4'd3,
      OP_INS_BEFORE = 4'd4,
      OP_INS_AFTER  = 4'd5,
      OP_GET_BEFORE = 4'd6,
      OP_GET_AFTER  = 4'd7,
      OP_SET_BEFORE = 4'd8,
      OP_SET_AFTER  = 4'd9,
      OP_DEL_BEFORE = 4'd10,
      OP_DEL_AFTER  = 4'd11
   } cll_op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_BOUNDARY = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_BAD_OP   = 2'd3
   } cll_status_type;

   typedef enum logic {
      SQ_IDLE,
      SQ_RUN
   } cll_state_type;

   // sequencing of the micro program
   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_BRANCH_AFTER,
      SEQ_DONE,
      SEQ_QUIT
   } cll_seq_type;

   // next_link write port: address <- data
   typedef enum logic [2:0] {
      NW_NONE,
      NW_UNLINK,   // next[prev_rd] <- next_rd
      NW_FREE,     // next[a]       <- free_head
      NW_NEW,      // next[n]       <- cursor
      NW_BEFORE    // next[b]       <- n
   } cll_nw_type;

   // prev_link write port
   typedef enum logic [2:0] {
      PW_NONE,
      PW_INIT,     // prev[end]     <- start
      PW_UNLINK,   // prev[next_rd] <- prev_rd
      PW_NEW,      // prev[n]       <- prev_rd
      PW_AFTER     // prev[cursor]  <- n
   } cll_pw_type;

   typedef enum logic [1:0] {
      VW_NONE,
      VW_BEFORE,   // value[prev_rd] <- word
      VW_AT,       // value[cursor]  <- word
      VW_NEW       // value[n]       <- word
   } cll_vw_type;

   typedef enum logic {
      NR_CUR,
      NR_FREE
   } cll_nr_type;

   typedef enum logic {
      VR_CUR,
      VR_BEFORE
   } cll_vr_type;

   typedef enum logic [2:0] {
      CU_HOLD,
      CU_FIRST,
      CU_END,
      CU_NEXT,
      CU_PREV,
      CU_NEW
   } cll_cu_type;

   typedef struct packed {
      cll_nr_type  nx_rd;
      cll_vr_type  vl_rd;
      cll_nw_type  nx_wr;
      cll_pw_type  pv_wr;
      cll_vw_type  vl_wr;
      cll_cu_type  cur_upd;
      logic        latch_a;
      logic        latch_b;
      logic        pick_n;
      logic        alloc;
      logic        release_node;
      logic        commit_ins;
      logic        load_dout;
      cll_seq_type seq;
      logic [UPC_W-1:0] target;
   } cll_uword_type;

   // micro program entry points
   localparam logic [UPC_W-1:0] UA_INIT  = 5'd0;
   localparam logic [UPC_W-1:0] UA_FIN   = 5'd1;
   localparam logic [UPC_W-1:0] UA_START = 5'd2;
   localparam logic [UPC_W-1:0] UA_END   = 5'd3;
   localparam logic [UPC_W-1:0] UA_FWD   = 5'd4;
   localparam logic [UPC_W-1:0] UA_BWD   = 5'd6;
   localparam logic [UPC_W-1:0] UA_GB    = 5'd8;
   localparam logic [UPC_W-1:0] UA_GA    = 5'd11;
   localparam logic [UPC_W-1:0] UA_SB    = 5'd13;
   localparam logic [UPC_W-1:0] UA_SA    = 5'd15;
   localparam logic [UPC_W-1:0] UA_DB    = 5'd16;
   localparam logic [UPC_W-1:0] UA_UNL   = 5'd18;
   localparam logic [UPC_W-1:0] UA_INS   = 5'd21;
   localparam logic [UPC_W-1:0] UA_INS_A = 5'd24;

   function automatic cll_uword_type cll_urom(input logic [UPC_W-1:0] addr);
      cll_uword_type w;
      w = '{nx_rd: NR_CUR, vl_rd: VR_CUR, nx_wr: NW_NONE, pv_wr: PW_NONE,
            vl_wr: VW_NONE, cur_upd: CU_HOLD, latch_a: 1'b0, latch_b: 1'b0,
            pick_n: 1'b0, alloc: 1'b0, release_node: 1'b0, commit_ins: 1'b0,
            load_dout: 1'b0, seq: SEQ_NEXT, target: UA_INIT};
      case (addr)
         5'd0: begin w.pv_wr = PW_INIT; w.seq = SEQ_QUIT; end
         5'd1: begin w.seq = SEQ_DONE; end
         5'd2: begin w.cur_upd = CU_FIRST; w.seq = SEQ_DONE; end
         5'd3: begin w.cur_upd = CU_END; w.seq = SEQ_DONE; end
         5'd4: begin w.nx_rd = NR_CUR; end
         5'd5: begin w.cur_upd = CU_NEXT; w.seq = SEQ_DONE; end
         5'd6: begin w.seq = SEQ_NEXT; end
         5'd7: begin w.cur_upd = CU_PREV; w.seq = SEQ_DONE; end
         5'd8: begin w.seq = SEQ_NEXT; end
         5'd9: begin w.vl_rd = VR_BEFORE; end
         5'd10: begin w.load_dout = 1'b1; w.seq = SEQ_DONE; end
         5'd11: begin w.vl_rd = VR_CUR; end
         5'd12: begin w.load_dout = 1'b1; w.seq = SEQ_DONE; end
         5'd13: begin w.seq = SEQ_NEXT; end
         5'd14: begin w.vl_wr = VW_BEFORE; w.seq = SEQ_DONE; end
         5'd15: begin w.vl_wr = VW_AT; w.seq = SEQ_DONE; end
         5'd16: begin w.seq = SEQ_NEXT; end
         // step back onto the node before, then fall into the unlink
         5'd17: begin w.cur_upd = CU_PREV; end
         5'd18: begin w.nx_rd = NR_CUR; end
         5'd19: begin
            w.nx_wr = NW_UNLINK; w.pv_wr = PW_UNLINK;
            w.latch_a = 1'b1; w.cur_upd = CU_NEXT;
         end
         5'd20: begin w.nx_wr = NW_FREE; w.release_node = 1'b1; w.seq = SEQ_DONE; end
         5'd21: begin w.nx_rd = NR_FREE; w.pick_n = 1'b1; end
         5'd22: begin
            w.nx_wr = NW_NEW; w.pv_wr = PW_NEW; w.vl_wr = VW_NEW;
            w.latch_b = 1'b1; w.alloc = 1'b1;
            w.seq = SEQ_BRANCH_AFTER; w.target = UA_INS_A;
         end
         5'd23: begin
            w.nx_wr = NW_BEFORE; w.pv_wr = PW_AFTER; w.commit_ins = 1'b1;
            w.seq = SEQ_DONE;
         end
         5'd24: begin
            w.nx_wr = NW_BEFORE; w.pv_wr = PW_AFTER; w.commit_ins = 1'b1;
            w.cur_upd = CU_NEW; w.seq = SEQ_DONE;
         end
         default: begin w.seq = SEQ_DONE; end
      endcase
      return w;
   endfunction

   function automatic cll_status_type cll_status(input logic [OP_W-1:0] op,
         input logic at_s, input logic at_e, input logic full);
      cll_status_type st;
      case (cll_op_type'(op))
         OP_START, OP_END: st = STAT_OK;
         OP_FORWARD, OP_GET_AFTER, OP_SET_AFTER, OP_DEL_AFTER:
            st = at_e ? STAT_BOUNDARY : STAT_OK;
         OP_BACKWARD, OP_GET_BEFORE, OP_SET_BEFORE, OP_DEL_BEFORE:
            st = at_s ? STAT_BOUNDARY : STAT_OK;
         OP_INS_BEFORE, OP_INS_AFTER: st = full ? STAT_FULL : STAT_OK;
         default: st = STAT_BAD_OP;
      endcase
      return st;
   endfunction

   function automatic logic [UPC_W-1:0] cll_entry(input logic [OP_W-1:0] op);
      logic [UPC_W-1:0] a;
      case (cll_op_type'(op))
         OP_START:      a = UA_START;
         OP_END:        a = UA_END;
         OP_FORWARD:    a = UA_FWD;
         OP_BACKWARD:   a = UA_BWD;
         OP_INS_BEFORE: a = UA_INS;
         OP_INS_AFTER:  a = UA_INS;
         OP_GET_BEFORE: a = UA_GB;
         OP_GET_AFTER:  a = UA_GA;
         OP_SET_BEFORE: a = UA_SB;
         OP_SET_AFTER:  a = UA_SA;
         OP_DEL_BEFORE: a = UA_DB;
         OP_DEL_AFTER:  a = UA_UNL;
         default:       a = UA_FIN;
      endcase
      return a;
   endfunction

endpackage

// ===== hdl/cursor_linked_list.sv =====
// Cursor linked list: microcoded sequencer over next/prev/value node memories.
// Each accepted request runs the micro program of its op; a rejected request runs only the
// finish step, which loads the result with its status.
// One request at a time: req_tready returns the cycle after the result is loaded, and a
// held result stalls the last micro step.
// Reset: the init micro step links the end sentinel back to the start, then req_tready rises.
`timescale 1ns / 1ps

module cursor_linked_list #(
   parameter int CAPACITY   = cll_pkg::CLL_CAPACITY,
   parameter int DATA_WIDTH = cll_pkg::CLL_DATA_WIDTH,
   localparam int CNT_W     = $clog2(CAPACITY + 1),
   localparam int RSP_W     = ((cll_pkg::WORD_W + cll_pkg::STAT_W + 2 + CNT_W + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [cll_pkg::REQ_W-1:0] req_tdata,  // op[3:0], data_in[35:4]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata    // data_out, status, at_start, at_end, node_count
);

   localparam int SLOTS  = CAPACITY + 2;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_W-1:0] START_SLOT = SLOT_W'(CAPACITY);
   localparam logic [SLOT_W-1:0] END_SLOT   = SLOT_W'(CAPACITY + 1);
   localparam logic [CNT_W-1:0]  CAP_CNT    = CNT_W'(CAPACITY);

   // node memories
   logic [SLOT_W-1:0]     nx_mem [SLOTS];
   logic [SLOT_W-1:0]     pv_mem [SLOTS];
   logic [DATA_WIDTH-1:0] vl_mem [SLOTS];

   logic [SLOT_W-1:0]     nx_rd_ff, pv_rd_ff;
   logic [DATA_WIDTH-1:0] vl_rd_ff;

   cll_pkg::cll_state_type state_ff, state_in;
   logic [cll_pkg::UPC_W-1:0] upc_ff, upc_in;

   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] first_ff, first_in;   // mirror of next_link[start]
   logic [SLOT_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;         // pool slots never handed out start here
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] a_ff, a_in, b_ff, b_in, n_ff, n_in;

   logic [cll_pkg::OP_W-1:0]   op_ff;
   logic [cll_pkg::WORD_W-1:0] word_ff;
   logic [cll_pkg::STAT_W-1:0] status_ff;
   logic [cll_pkg::WORD_W-1:0] dout_ff, dout_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   cll_pkg::cll_uword_type uw;
   logic accept, stall, go, at_s, at_e, full, recycled;

   logic              nx_we, pv_we, vl_we;
   logic [SLOT_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd, vl_wa, nx_ra, vl_ra;
   logic [DATA_WIDTH-1:0] vl_wd;
   logic [63:0] word_wide, rd_wide;

   assign uw        = cll_pkg::cll_urom(upc_ff);
   assign at_s      = (cur_ff == first_ff);
   assign at_e      = (cur_ff == END_SLOT);
   assign full      = (cnt_ff == CAP_CNT);
   assign recycled  = (hw_ff != cnt_ff);
   assign word_wide = 64'(word_ff);
   assign vl_wd     = word_wide[DATA_WIDTH-1:0];
   assign rd_wide   = 64'(vl_rd_ff);

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      upc_in   = upc_ff;
      case (state_ff)
         cll_pkg::SQ_IDLE: begin
            if (accept) begin
               state_in = cll_pkg::SQ_RUN;
               upc_in   = (cll_pkg::cll_status(req_tdata[cll_pkg::OP_W-1:0], at_s, at_e, full)
                           == cll_pkg::STAT_OK)
                          ? cll_pkg::cll_entry(req_tdata[cll_pkg::OP_W-1:0]) : cll_pkg::UA_FIN;
            end
         end
         cll_pkg::SQ_RUN: begin
            if (go) begin
               case (uw.seq)
                  cll_pkg::SEQ_NEXT: upc_in = upc_ff + 1'b1;
                  cll_pkg::SEQ_BRANCH_AFTER:
                     upc_in = (op_ff == cll_pkg::OP_INS_AFTER) ? uw.target : upc_ff + 1'b1;
                  cll_pkg::SEQ_DONE, cll_pkg::SEQ_QUIT: state_in = cll_pkg::SQ_IDLE;
                  default: state_in = cll_pkg::SQ_IDLE;
               endcase
            end
         end
         default: state_in = cll_pkg::SQ_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready = 1'b0;
      stall      = 1'b0;
      go         = 1'b0;
      case (state_ff)
         cll_pkg::SQ_IDLE: req_tready = 1'b1;
         cll_pkg::SQ_RUN: begin
            // a finished step waits while the previous result is still held
            stall = (uw.seq == cll_pkg::SEQ_DONE) && rsp_valid_ff && !rsp_tready;
            go    = !stall;
         end
         default: req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // memory port selection
   always_comb begin
      nx_we = 1'b0; nx_wa = nx_rd_ff; nx_wd = pv_rd_ff;
      case (uw.nx_wr)
         cll_pkg::NW_UNLINK: begin nx_we = 1'b1; nx_wa = pv_rd_ff; nx_wd = nx_rd_ff; end
         cll_pkg::NW_FREE:   begin nx_we = 1'b1; nx_wa = a_ff;     nx_wd = free_ff;  end
         cll_pkg::NW_NEW:    begin nx_we = 1'b1; nx_wa = n_ff;     nx_wd = cur_ff;   end
         cll_pkg::NW_BEFORE: begin nx_we = 1'b1; nx_wa = b_ff;     nx_wd = n_ff;     end
         default: nx_we = 1'b0;
      endcase
      nx_we = nx_we && go;

      pv_we = 1'b0; pv_wa = END_SLOT; pv_wd = START_SLOT;
      case (uw.pv_wr)
         cll_pkg::PW_INIT:   begin pv_we = 1'b1; pv_wa = END_SLOT; pv_wd = START_SLOT; end
         cll_pkg::PW_UNLINK: begin pv_we = 1'b1; pv_wa = nx_rd_ff; pv_wd = pv_rd_ff; end
         cll_pkg::PW_NEW:    begin pv_we = 1'b1; pv_wa = n_ff;     pv_wd = pv_rd_ff; end
         cll_pkg::PW_AFTER:  begin pv_we = 1'b1; pv_wa = cur_ff;   pv_wd = n_ff;     end
         default: pv_we = 1'b0;
      endcase
      pv_we = pv_we && go;

      vl_we = 1'b0; vl_wa = cur_ff;
      case (uw.vl_wr)
         cll_pkg::VW_BEFORE: begin vl_we = 1'b1; vl_wa = pv_rd_ff; end
         cll_pkg::VW_AT:     begin vl_we = 1'b1; vl_wa = cur_ff;   end
         cll_pkg::VW_NEW:    begin vl_we = 1'b1; vl_wa = n_ff;     end
         default: vl_we = 1'b0;
      endcase
      vl_we = vl_we && go;

      nx_ra = (uw.nx_rd == cll_pkg::NR_FREE) ? free_ff : cur_ff;
      vl_ra = (uw.vl_rd == cll_pkg::VR_BEFORE) ? pv_rd_ff : cur_ff;
   end

   always_ff @(posedge clock) begin
      if (nx_we) nx_mem[nx_wa] <= nx_wd;
      if (pv_we) pv_mem[pv_wa] <= pv_wd;
      if (vl_we) vl_mem[vl_wa] <= vl_wd;
      if (go) begin
         nx_rd_ff <= nx_mem[nx_ra];
         pv_rd_ff <= pv_mem[cur_ff];
         vl_rd_ff <= vl_mem[vl_ra];
      end
   end

   // datapath next values
   always_comb begin
      cur_in   = cur_ff;
      first_in = first_ff;
      free_in  = free_ff;
      hw_in    = hw_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      n_in     = n_ff;
      dout_in  = dout_ff;
      if (accept) dout_in = '0;
      if (go) begin
         case (uw.cur_upd)
            cll_pkg::CU_FIRST: cur_in = first_ff;
            cll_pkg::CU_END:   cur_in = END_SLOT;
            cll_pkg::CU_NEXT:  cur_in = nx_rd_ff;
            cll_pkg::CU_PREV:  cur_in = pv_rd_ff;
            cll_pkg::CU_NEW:   cur_in = n_ff;
            default:           cur_in = cur_ff;
         endcase
         if (nx_we && nx_wa == START_SLOT) first_in = nx_wd;
         if (uw.latch_a) a_in = cur_ff;
         if (uw.latch_b) b_in = pv_rd_ff;
         if (uw.pick_n) n_in = recycled ? free_ff : SLOT_W'(hw_ff);
         if (uw.alloc) begin
            if (recycled) free_in = nx_rd_ff;
            else          hw_in   = hw_ff + 1'b1;
         end
         if (uw.release_node) begin
            free_in = a_ff;
            cnt_in  = cnt_ff - 1'b1;
         end
         if (uw.commit_ins) cnt_in = cnt_ff + 1'b1;
         if (uw.load_dout) dout_in = rd_wide[cll_pkg::WORD_W-1:0];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (go && uw.seq == cll_pkg::SEQ_DONE) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({cnt_in, (cur_in == END_SLOT), (cur_in == first_in),
                                status_ff, dout_in});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cll_pkg::SQ_RUN;
         upc_ff       <= cll_pkg::UA_INIT;
         cur_ff       <= END_SLOT;
         first_ff     <= END_SLOT;
         free_ff      <= '0;
         hw_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         cur_ff       <= cur_in;
         first_ff     <= first_in;
         free_ff      <= free_in;
         hw_ff        <= hw_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      n_ff        <= n_in;
      dout_ff     <= dout_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         op_ff     <= req_tdata[cll_pkg::OP_W-1:0];
         word_ff   <= req_tdata[cll_pkg::OP_W +: cll_pkg::WORD_W];
         status_ff <= cll_pkg::cll_status(req_tdata[cll_pkg::OP_W-1:0], at_s, at_e, full);
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking stream testbench for the cursor linked list block.
`timescale 1ns / 1ps

module testbench;

   localparam int OP_W      = cll_pkg::OP_W;
   localparam int WORD_W    = cll_pkg::WORD_W;
   localparam int STAT_W    = cll_pkg::STAT_W;
   localparam int REQ_W     = cll_pkg::REQ_W;
   localparam int CAPACITY  = cll_pkg::CLL_CAPACITY;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int RSP_BITS  = ((WORD_W + STAT_W + 2 + CNT_W + 7) / 8) * 8;
   localparam int STAT_LSB  = WORD_W;
   localparam int START_BIT = WORD_W + STAT_W;
   localparam int END_BIT   = START_BIT + 1;
   localparam int CNT_LSB   = END_BIT + 1;
   localparam int SLOT_W    = 7;
   localparam int START_SLOT = CAPACITY;
   localparam int END_SLOT   = CAPACITY + 1;
   localparam int ROUNDS      = 8;
   localparam int ROUND_ITEMS = 125;

   // codes outside the operation set
   localparam logic [OP_W-1:0] BAD_OP_C = 4'd12;
   localparam logic [OP_W-1:0] BAD_OP_F = 4'd15;

   typedef struct packed {
      logic [WORD_W-1:0]       data_out;
      cll_pkg::cll_status_type status;
      logic                    at_start;
      logic                    at_end;
      logic [CNT_W-1:0]        node_count;
   } list_rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [WORD_W-1:0]       word;
      logic                    typed;
      cll_pkg::cll_status_type status;
      logic                    at_start;
      logic                    at_end;
      logic [CNT_W-1:0]        node_count;
   } dir_row_type;

   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_BALANCED,
      MIX_DRAIN
   } op_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count = 0;

   list_rsp_type due_rsp [$];

   // shadow of the list
   logic [SLOT_W-1:0] link_fwd [0:END_SLOT];
   logic [SLOT_W-1:0] link_bwd [0:END_SLOT];
   logic [WORD_W-1:0] word_mem [0:END_SLOT];
   logic [SLOT_W-1:0] cur_node;
   logic [SLOT_W-1:0] free_slot;
   logic [CNT_W-1:0]  live_nodes;

   const cll_pkg::cll_op_type plain_ops [8] = '{cll_pkg::OP_START, cll_pkg::OP_END,
      cll_pkg::OP_FORWARD, cll_pkg::OP_BACKWARD, cll_pkg::OP_GET_BEFORE,
      cll_pkg::OP_GET_AFTER, cll_pkg::OP_SET_BEFORE, cll_pkg::OP_SET_AFTER};

   // rows marked typed carry their expected result (all on the empty list); the rest go through the shadow
   const dir_row_type dir_tab [24] = '{
      '{cll_pkg::OP_GET_AFTER,  32'h0,        1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_GET_BEFORE, 32'h0,        1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_FORWARD,    32'h0,        1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_BACKWARD,   32'h0,        1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_SET_BEFORE, 32'hFFFFFFFF, 1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_SET_AFTER,  32'hFFFFFFFF, 1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_DEL_BEFORE, 32'h0,        1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_DEL_AFTER,  32'h0,        1'b1, cll_pkg::STAT_BOUNDARY, 1'b1, 1'b1, 7'd0},
      '{BAD_OP_C,               32'hFFFFFFFF, 1'b1, cll_pkg::STAT_BAD_OP,   1'b1, 1'b1, 7'd0},
      '{BAD_OP_F,               32'h0,        1'b1, cll_pkg::STAT_BAD_OP,   1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_START,      32'h0,        1'b1, cll_pkg::STAT_OK,       1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_END,        32'h0,        1'b1, cll_pkg::STAT_OK,       1'b1, 1'b1, 7'd0},
      '{cll_pkg::OP_INS_BEFORE, 32'hFFFFFFFF, 1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_INS_AFTER,  32'h00000000, 1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_GET_AFTER,  32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_GET_BEFORE, 32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_SET_AFTER,  32'h5A5A5A5A, 1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_SET_BEFORE, 32'hA5A5A5A5, 1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_START,      32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_FORWARD,    32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_DEL_BEFORE, 32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_BACKWARD,   32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_DEL_AFTER,  32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0},
      '{cll_pkg::OP_GET_BEFORE, 32'h0,        1'b0, cll_pkg::STAT_OK,       1'b0, 1'b0, 7'd0}
   };

   cursor_linked_list DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_list();
      for (int i = 0; i <= END_SLOT; i++) begin
         link_fwd[i] = (i < CAPACITY - 1) ? SLOT_W'(i + 1) : '0;
         link_bwd[i] = '0;
         word_mem[i] = '0;
      end
      link_fwd[START_SLOT] = END_SLOT;
      link_bwd[END_SLOT]   = START_SLOT;
      cur_node   = END_SLOT;
      free_slot  = '0;
      live_nodes = '0;
   endfunction

   // drop the node after the cursor onto the free chain; cursor moves to its successor
   function automatic void unlink_cursor_node();
      logic [SLOT_W-1:0] c, n, b;
      c = cur_node;
      n = link_fwd[c];
      b = link_bwd[c];
      link_fwd[b] = n;
      link_bwd[n] = b;
      link_fwd[c] = free_slot;
      free_slot = c;
      if (live_nodes > 0)
         live_nodes--;
      cur_node = n;
   endfunction

   function automatic list_rsp_type apply_list_op(input logic [OP_W-1:0] op,
         input logic [WORD_W-1:0] word);
      list_rsp_type r;
      logic s, e;
      logic [SLOT_W-1:0] n, b;
      r = '0;
      r.status = cll_pkg::STAT_OK;
      s = (cur_node == link_fwd[START_SLOT]);
      e = (cur_node == END_SLOT);
      case (op)
         cll_pkg::OP_START: cur_node = link_fwd[START_SLOT];
         cll_pkg::OP_END: cur_node = END_SLOT;
         cll_pkg::OP_FORWARD: begin
            if (e) r.status = cll_pkg::STAT_BOUNDARY;
            else cur_node = link_fwd[cur_node];
         end
         cll_pkg::OP_BACKWARD: begin
            if (s) r.status = cll_pkg::STAT_BOUNDARY;
            else cur_node = link_bwd[cur_node];
         end
         cll_pkg::OP_INS_BEFORE, cll_pkg::OP_INS_AFTER: begin
            if (live_nodes >= CAPACITY) begin
               r.status = cll_pkg::STAT_FULL;
            end else begin
               n = free_slot;
               b = link_bwd[cur_node];
               free_slot = link_fwd[n];
               word_mem[n] = word;
               link_fwd[n] = cur_node;
               link_bwd[n] = b;
               link_bwd[cur_node] = n;
               link_fwd[b] = n;
               live_nodes++;
               if (op == cll_pkg::OP_INS_AFTER)
                  cur_node = n;
            end
         end
         cll_pkg::OP_GET_BEFORE: begin
            if (s) r.status = cll_pkg::STAT_BOUNDARY;
            else r.data_out = word_mem[link_bwd[cur_node]];
         end
         cll_pkg::OP_GET_AFTER: begin
            if (e) r.status = cll_pkg::STAT_BOUNDARY;
            else r.data_out = word_mem[cur_node];
         end
         cll_pkg::OP_SET_BEFORE: begin
            if (s) r.status = cll_pkg::STAT_BOUNDARY;
            else word_mem[link_bwd[cur_node]] = word;
         end
         cll_pkg::OP_SET_AFTER: begin
            if (e) r.status = cll_pkg::STAT_BOUNDARY;
            else word_mem[cur_node] = word;
         end
         cll_pkg::OP_DEL_BEFORE: begin
            if (s) begin
               r.status = cll_pkg::STAT_BOUNDARY;
            end else begin
               cur_node = link_bwd[cur_node];
               unlink_cursor_node();
            end
         end
         cll_pkg::OP_DEL_AFTER: begin
            if (e) r.status = cll_pkg::STAT_BOUNDARY;
            else unlink_cursor_node();
         end
         default: r.status = cll_pkg::STAT_BAD_OP;
      endcase
      r.at_start   = (cur_node == link_fwd[START_SLOT]);
      r.at_end     = (cur_node == END_SLOT);
      r.node_count = live_nodes;
      return r;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input op_mix_type mix);
      int ins_pct, del_pct, roll;
      ins_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 8 : 20;
      del_pct = (mix == MIX_FILL) ? 5 : (mix == MIX_DRAIN) ? 55 : 20;
      roll = $urandom_range(99);
      if (roll < 3)
         return BAD_OP_C + OP_W'($urandom_range(3));
      if (roll < 3 + ins_pct)
         return $urandom_range(1) ? cll_pkg::OP_INS_AFTER : cll_pkg::OP_INS_BEFORE;
      if (roll < 3 + ins_pct + del_pct)
         return $urandom_range(1) ? cll_pkg::OP_DEL_AFTER : cll_pkg::OP_DEL_BEFORE;
      return plain_ops[$urandom_range(7)];
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
         input logic typed, input list_rsp_type typed_rsp);
      list_rsp_type p;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - OP_W - WORD_W){1'b0}}, word, op};
      do @(posedge clock); while (!req_tready);
      p = apply_list_op(op, word);
      due_rsp.push_back(typed ? typed_rsp : p);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (due_rsp.size() != 0);
   endtask

   // response check and receiver stalls
   always @(posedge clock) begin
      list_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data_out   = rsp_tdata[WORD_W-1:0];
         got.status     = cll_pkg::cll_status_type'(rsp_tdata[STAT_LSB +: STAT_W]);
         got.at_start   = rsp_tdata[START_BIT];
         got.at_end     = rsp_tdata[END_BIT];
         got.node_count = rsp_tdata[CNT_LSB +: CNT_W];
         if (due_rsp.size() == 0) begin
            $error("response with no request pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = due_rsp.pop_front();
            if (got.data_out !== want.data_out) begin
               $error("data_out: expected %h, got %h", want.data_out, got.data_out);
               fail_count++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               fail_count++;
            end
            if (got.at_start !== want.at_start) begin
               $error("at_start: expected %b, got %b", want.at_start, got.at_start);
               fail_count++;
            end
            if (got.at_end !== want.at_end) begin
               $error("at_end: expected %b, got %b", want.at_end, got.at_end);
               fail_count++;
            end
            if (got.node_count !== want.node_count) begin
               $error("node_count: expected %0d, got %0d", want.node_count,
                      got.node_count);
               fail_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      op_mix_type mix_plan [ROUNDS];
      list_rsp_type typed_rsp;
      mix_plan = '{MIX_FILL, MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_DRAIN,
                   MIX_BALANCED, MIX_FILL, MIX_DRAIN};
      clear_list();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         typed_rsp = '{data_out: '0, status: dir_tab[i].status,
                       at_start: dir_tab[i].at_start, at_end: dir_tab[i].at_end,
                       node_count: dir_tab[i].node_count};
         send_request(dir_tab[i].op, dir_tab[i].word, dir_tab[i].typed, typed_rsp);
      end

      for (int r = 0; r < ROUNDS; r++) begin
         // hold the sender until the block has answered everything
         req_tvalid <= 1'b0;
         wait_drained();
         case (r % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 52; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 52; end
            default: begin req_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         for (int k = 0; k < ROUND_ITEMS; k++)
            send_request(pick_op(mix_plan[r]), pick_word(), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cll_pkg.sv
hdl/cursor_linked_list.sv
tb/testbench.sv
